### hdl/ehr_pkg.sv
package ehr_pkg;

    localparam int RING_DEPTH = 32;
    localparam int ADDR_W = $clog2(RING_DEPTH);
    localparam int COUNT_W = 6;
    localparam int AGE_W = 6;
    localparam logic [31:0] THROTTLE_RESET = 32'd60000;

    typedef enum logic [1:0] {
        CMD_LOG  = 2'd0,
        CMD_READ = 2'd1,
        CMD_TICK = 2'd2,
        CMD_NOP  = 2'd3
    } cmd_t;

    typedef struct packed {
        logic [31:0] param_one;
        logic [15:0] param_two;
        logic [7:0]  alarm_id;
        logic [7:0]  event_type;
    } event_t;

    localparam int EVENT_W = $bits(event_t);

    typedef struct packed {
        logic               ok;
        logic               save_now;
        logic               hit;
        logic [COUNT_W-1:0] count;
    } stage_t;

endpackage

### hdl/event_history_ring_with_save_throttle.sv
// channel  | handshake                | payload
// ---------+--------------------------+---------------------------------------------
// cfg      | cfg_we                   | cfg_wdata (save throttle, ms)
// in       | in_valid / in_ready      | command, event fields, age_index, now_ms
// out      | out_valid / out_ready    | ok, save_now, entry_count, out_* fields
//
// one item per cycle sustained while the receiver keeps out_ready high; a result
// passes the registered ring read and then the output register
// rst_n clears ring pointer, count, pending save and last save time; throttle to 60000
// ring contents are not cleared and are only read below the entry count
// a stalled output holds one result in the output register and one in the read stage
module event_history_ring_with_save_throttle import ehr_pkg::*; (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_we,
    input  logic [31:0]        cfg_wdata,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [1:0]         command,
    input  logic [7:0]         event_type,
    input  logic [7:0]         alarm_id,
    input  logic [31:0]        param_one,
    input  logic [15:0]        param_two,
    input  logic [31:0]        stamp_seconds,
    input  logic [AGE_W-1:0]   age_index,
    input  logic [31:0]        now_ms,
    output logic               out_valid,
    input  logic               out_ready,
    output logic               ok,
    output logic               save_now,
    output logic [COUNT_W-1:0] entry_count,
    output logic [7:0]         out_type,
    output logic [7:0]         out_alarm,
    output logic [31:0]        out_param_one,
    output logic [15:0]        out_param_two,
    output logic [31:0]        out_stamp
);

    logic              advance;
    logic              s1_valid;
    stage_t            s1;
    logic              wr_en;
    logic [ADDR_W-1:0] wr_addr;
    event_t            ev_wdata;
    logic [31:0]       st_wdata;
    logic              rd_en;
    logic [ADDR_W-1:0] rd_addr;
    event_t            ev_rdata;
    logic [31:0]       st_rdata;

    ehr_ctrl u_ctrl (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_wdata     (cfg_wdata),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .command       (command),
        .event_type    (event_type),
        .alarm_id      (alarm_id),
        .param_one     (param_one),
        .param_two     (param_two),
        .stamp_seconds (stamp_seconds),
        .age_index     (age_index),
        .now_ms        (now_ms),
        .advance       (advance),
        .s1_valid      (s1_valid),
        .s1            (s1),
        .wr_en         (wr_en),
        .wr_addr       (wr_addr),
        .ev_wdata      (ev_wdata),
        .st_wdata      (st_wdata),
        .rd_en         (rd_en),
        .rd_addr       (rd_addr)
    );

    ehr_ram #(
        .WIDTH (EVENT_W),
        .DEPTH (RING_DEPTH)
    ) u_event_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (ev_wdata),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (ev_rdata)
    );

    ehr_ram #(
        .WIDTH (32),
        .DEPTH (RING_DEPTH)
    ) u_stamp_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (st_wdata),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (st_rdata)
    );

    ehr_out u_out (
        .clk           (clk),
        .rst_n         (rst_n),
        .s1_valid      (s1_valid),
        .s1            (s1),
        .ev_rdata      (ev_rdata),
        .st_rdata      (st_rdata),
        .advance       (advance),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .ok            (ok),
        .save_now      (save_now),
        .entry_count   (entry_count),
        .out_type      (out_type),
        .out_alarm     (out_alarm),
        .out_param_one (out_param_one),
        .out_param_two (out_param_two),
        .out_stamp     (out_stamp)
    );

endmodule

### hdl/ehr_ram.sv
module ehr_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

### hdl/ehr_ctrl.sv
module ehr_ctrl import ehr_pkg::*; (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_we,
    input  logic [31:0]        cfg_wdata,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [1:0]         command,
    input  logic [7:0]         event_type,
    input  logic [7:0]         alarm_id,
    input  logic [31:0]        param_one,
    input  logic [15:0]        param_two,
    input  logic [31:0]        stamp_seconds,
    input  logic [AGE_W-1:0]   age_index,
    input  logic [31:0]        now_ms,
    input  logic               advance,
    output logic               s1_valid,
    output stage_t             s1,
    output logic               wr_en,
    output logic [ADDR_W-1:0]  wr_addr,
    output event_t             ev_wdata,
    output logic [31:0]        st_wdata,
    output logic               rd_en,
    output logic [ADDR_W-1:0]  rd_addr
);

    logic [31:0]        throttle_reg;
    logic [ADDR_W-1:0]  wp_reg, wp_next;
    logic [COUNT_W-1:0] count_reg, count_next;
    logic               pending_reg, pending_next;
    logic [31:0]        last_save_reg, last_save_next;
    logic               s1_valid_reg, s1_valid_next;
    stage_t             s1_reg, s1_next;

    cmd_t               cmd;
    logic               accept;
    logic               hit;
    logic               fire;
    logic [31:0]        elapsed;
    logic [ADDR_W:0]    back_sum;

    assign cmd      = cmd_t'(command);
    assign in_ready = !s1_valid_reg || advance;
    assign accept   = in_valid && in_ready;
    assign hit      = age_index < count_reg;
    assign elapsed  = now_ms - last_save_reg;
    assign fire     = pending_reg && (elapsed >= throttle_reg);

    // age 0 is the slot just behind the write position
    assign back_sum = {1'b0, wp_reg} + (ADDR_W+1)'(RING_DEPTH - 1)
                      - {1'b0, age_index[ADDR_W-1:0]};

    always_comb
    begin
        if (back_sum >= (ADDR_W+1)'(RING_DEPTH))
        begin
            rd_addr = ADDR_W'(back_sum - (ADDR_W+1)'(RING_DEPTH));
        end
        else
        begin
            rd_addr = back_sum[ADDR_W-1:0];
        end
    end

    assign wr_en    = accept && (cmd == CMD_LOG);
    assign wr_addr  = wp_reg;
    assign ev_wdata = '{param_one: param_one, param_two: param_two,
                        alarm_id: alarm_id, event_type: event_type};
    assign st_wdata = stamp_seconds;
    assign rd_en    = accept && (cmd == CMD_READ) && hit;

    always_comb
    begin
        wp_next        = wp_reg;
        count_next     = count_reg;
        pending_next   = pending_reg;
        last_save_next = last_save_reg;
        s1_next        = s1_reg;
        s1_valid_next  = s1_valid_reg;
        if (advance)
        begin
            s1_valid_next = 1'b0;
        end
        if (accept)
        begin
            s1_valid_next    = 1'b1;
            s1_next.ok       = 1'b0;
            s1_next.save_now = 1'b0;
            s1_next.hit      = 1'b0;
            case (cmd)
                CMD_LOG:
                begin
                    if (wp_reg == ADDR_W'(RING_DEPTH - 1))
                    begin
                        wp_next = '0;
                    end
                    else
                    begin
                        wp_next = wp_reg + ADDR_W'(1);
                    end
                    if (count_reg != COUNT_W'(RING_DEPTH))
                    begin
                        count_next = count_reg + COUNT_W'(1);
                    end
                    pending_next = 1'b1;
                    s1_next.ok   = 1'b1;
                end
                CMD_READ:
                begin
                    s1_next.ok  = hit;
                    s1_next.hit = hit;
                end
                CMD_TICK:
                begin
                    if (fire)
                    begin
                        pending_next     = 1'b0;
                        last_save_next   = now_ms;
                        s1_next.ok       = 1'b1;
                        s1_next.save_now = 1'b1;
                    end
                end
                default:
                begin
                end
            endcase
            s1_next.count = count_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            throttle_reg  <= THROTTLE_RESET;
            wp_reg        <= '0;
            count_reg     <= '0;
            pending_reg   <= 1'b0;
            last_save_reg <= '0;
            s1_valid_reg  <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                throttle_reg <= cfg_wdata;
            end
            wp_reg        <= wp_next;
            count_reg     <= count_next;
            pending_reg   <= pending_next;
            last_save_reg <= last_save_next;
            s1_valid_reg  <= s1_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        s1_reg <= s1_next;
    end

    assign s1_valid = s1_valid_reg;
    assign s1       = s1_reg;

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= COUNT_W'(RING_DEPTH))
        else $error("entry count above ring depth");

    a_log_pends: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && cmd == CMD_LOG) |=> pending_reg)
        else $error("log did not set pending save");

    a_save_records: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && cmd == CMD_TICK && fire) |=>
            (!pending_reg && last_save_reg == $past(now_ms)))
        else $error("signalled save not recorded");

    a_full_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && cmd == CMD_LOG && count_reg == COUNT_W'(RING_DEPTH)) |=>
            count_reg == COUNT_W'(RING_DEPTH))
        else $error("full ring count changed on log");

endmodule

### hdl/ehr_out.sv
module ehr_out import ehr_pkg::*; (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               s1_valid,
    input  stage_t             s1,
    input  event_t             ev_rdata,
    input  logic [31:0]        st_rdata,
    output logic               advance,
    output logic               out_valid,
    input  logic               out_ready,
    output logic               ok,
    output logic               save_now,
    output logic [COUNT_W-1:0] entry_count,
    output logic [7:0]         out_type,
    output logic [7:0]         out_alarm,
    output logic [31:0]        out_param_one,
    output logic [15:0]        out_param_two,
    output logic [31:0]        out_stamp
);

    logic               out_valid_reg;
    logic               ok_reg;
    logic               save_now_reg;
    logic [COUNT_W-1:0] count_reg;
    event_t             event_reg;
    logic [31:0]        stamp_reg;

    assign advance = s1_valid && (!out_valid_reg || out_ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // entry fields read as zero unless a read found its entry
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            ok_reg       <= s1.ok;
            save_now_reg <= s1.save_now;
            count_reg    <= s1.count;
            event_reg    <= s1.hit ? ev_rdata : '0;
            stamp_reg    <= s1.hit ? st_rdata : '0;
        end
    end

    assign out_valid     = out_valid_reg;
    assign ok            = ok_reg;
    assign save_now      = save_now_reg;
    assign entry_count   = count_reg;
    assign out_type      = event_reg.event_type;
    assign out_alarm     = event_reg.alarm_id;
    assign out_param_one = event_reg.param_one;
    assign out_param_two = event_reg.param_two;
    assign out_stamp     = stamp_reg;

endmodule

### sim/tb_top.sv
`timescale 1ns / 100ps

module tb_top;
    import ehr_pkg::*;

    localparam int HOLD_CYCLES = 64;

    typedef struct {
        cmd_t        cmd;
        logic [7:0]  ev_type;
        logic [7:0]  alarm;
        logic [31:0] p1;
        logic [15:0] p2;
        logic [31:0] stamp;
        logic [5:0]  age;
        logic [31:0] now;
    } ring_cmd_t;

    typedef struct {
        logic               ok;
        logic               save;
        logic [COUNT_W-1:0] count;
        logic [7:0]         ev_type;
        logic [7:0]         alarm;
        logic [31:0]        p1;
        logic [15:0]        p2;
        logic [31:0]        stamp;
    } ring_result_t;

    logic               clk;
    logic               rst_n;
    logic               cfg_we;
    logic [31:0]        cfg_wdata;
    logic               in_valid;
    logic               in_ready;
    logic [1:0]         command;
    logic [7:0]         event_type;
    logic [7:0]         alarm_id;
    logic [31:0]        param_one;
    logic [15:0]        param_two;
    logic [31:0]        stamp_seconds;
    logic [AGE_W-1:0]   age_index;
    logic [31:0]        now_ms;
    logic               out_valid;
    logic               out_ready;
    logic               ok;
    logic               save_now;
    logic [COUNT_W-1:0] entry_count;
    logic [7:0]         out_type;
    logic [7:0]         out_alarm;
    logic [31:0]        out_param_one;
    logic [15:0]        out_param_two;
    logic [31:0]        out_stamp;

    // shadow of the history ring
    event_t             ring_events [RING_DEPTH];
    logic [31:0]        ring_stamps [RING_DEPTH];
    logic [ADDR_W-1:0]  wr_pos = '0;
    int unsigned        n_valid = 0;
    logic               pending = 1'b0;
    logic [31:0]        last_save_ms = '0;
    logic [31:0]        throttle_ms = THROTTLE_RESET;

    ring_result_t       result_q [$];
    int unsigned        mismatches = 0;
    int unsigned        sender_idle_pct = 0;
    int unsigned        stall_pct = 0;
    int unsigned        holds_requested = 0;
    int unsigned        holds_done = 0;
    int unsigned        n_items = 0;
    int unsigned        n_logs = 0;
    int unsigned        n_hits = 0;
    int unsigned        n_misses = 0;
    int unsigned        n_saves = 0;

    event_history_ring_with_save_throttle dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_wdata     (cfg_wdata),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .command       (command),
        .event_type    (event_type),
        .alarm_id      (alarm_id),
        .param_one     (param_one),
        .param_two     (param_two),
        .stamp_seconds (stamp_seconds),
        .age_index     (age_index),
        .now_ms        (now_ms),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .ok            (ok),
        .save_now      (save_now),
        .entry_count   (entry_count),
        .out_type      (out_type),
        .out_alarm     (out_alarm),
        .out_param_one (out_param_one),
        .out_param_two (out_param_two),
        .out_stamp     (out_stamp)
    );

    initial clk = 1'b0;
    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    function automatic ring_result_t ring_apply(ring_cmd_t it);
        ring_result_t r;
        int           rd;
        logic [31:0]  elapsed;
        r = '{default: '0};
        n_items++;
        case (it.cmd)
            CMD_LOG:
            begin
                ring_events[wr_pos] = '{param_one: it.p1, param_two: it.p2,
                                        alarm_id: it.alarm, event_type: it.ev_type};
                ring_stamps[wr_pos] = it.stamp;
                wr_pos = wr_pos + 1'b1;
                if (n_valid < RING_DEPTH)
                    n_valid++;
                pending = 1'b1;
                r.ok = 1'b1;
                n_logs++;
            end
            CMD_READ:
            begin
                if (it.age < n_valid)
                begin
                    rd = (int'(wr_pos) + 2 * RING_DEPTH - 1 - int'(it.age)) % RING_DEPTH;
                    r.ok      = 1'b1;
                    r.ev_type = ring_events[rd].event_type;
                    r.alarm   = ring_events[rd].alarm_id;
                    r.p1      = ring_events[rd].param_one;
                    r.p2      = ring_events[rd].param_two;
                    r.stamp   = ring_stamps[rd];
                    n_hits++;
                end
                else
                    n_misses++;
            end
            CMD_TICK:
            begin
                elapsed = it.now - last_save_ms;
                if (pending && elapsed >= throttle_ms)
                begin
                    pending = 1'b0;
                    last_save_ms = it.now;
                    r.ok = 1'b1;
                    r.save = 1'b1;
                    n_saves++;
                end
            end
            default: ;
        endcase
        r.count = COUNT_W'(n_valid);
        return r;
    endfunction

    function automatic ring_cmd_t mk_item(cmd_t c, logic [31:0] pat, logic [5:0] age,
                                          logic [31:0] now);
        ring_cmd_t it;
        it.cmd     = c;
        it.ev_type = pat[7:0];
        it.alarm   = pat[15:8];
        it.p1      = pat;
        it.p2      = pat[31:16];
        it.stamp   = ~pat;
        it.age     = age;
        it.now     = now;
        return it;
    endfunction

    function automatic ring_cmd_t random_cmd();
        ring_cmd_t   it;
        int unsigned pick;
        it.ev_type = 8'($urandom);
        it.alarm   = 8'($urandom);
        it.p1      = $urandom;
        it.p2      = 16'($urandom);
        it.stamp   = $urandom;
        it.age     = 6'($urandom);
        it.now     = $urandom;
        pick = $urandom_range(99);
        if (pick < 40)
            it.cmd = CMD_LOG;
        else if (pick < 75)
        begin
            it.cmd = CMD_READ;
            if (n_valid > 0 && $urandom_range(3) != 0)
                it.age = 6'($urandom_range(n_valid - 1));
        end
        else if (pick < 95)
        begin
            it.cmd = CMD_TICK;
            case ($urandom_range(2))
                0: it.now = last_save_ms + throttle_ms - 1 + $urandom_range(2);
                1: it.now = last_save_ms + $urandom_range(100);
                default: ;
            endcase
        end
        else
            it.cmd = CMD_NOP;
        return it;
    endfunction

    // one transfer per call, entered and left at a rising edge
    task automatic send_item(input ring_cmd_t it);
        if (sender_idle_pct > 0 && $urandom_range(99) < sender_idle_pct)
        begin
            in_valid <= 1'b0;
            do
                @(posedge clk);
            while ($urandom_range(99) < sender_idle_pct);
        end
        in_valid      <= 1'b1;
        command       <= it.cmd;
        event_type    <= it.ev_type;
        alarm_id      <= it.alarm;
        param_one     <= it.p1;
        param_two     <= it.p2;
        stamp_seconds <= it.stamp;
        age_index     <= it.age;
        now_ms        <= it.now;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        result_q.push_back(ring_apply(it));
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        while (result_q.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_throttle(input logic [31:0] v);
        drain();
        cfg_we    <= 1'b1;
        cfg_wdata <= v;
        @(posedge clk);
        cfg_we <= 1'b0;
        throttle_ms = v;
    endtask

    task automatic test_directed();
        send_item(mk_item(CMD_READ, 32'h0, 6'd0, 32'h0));
        send_item(mk_item(CMD_READ, 32'h0, 6'd63, 32'h0));
        send_item(mk_item(CMD_TICK, 32'h0, 6'd0, 32'hFFFF_FFFF));
        send_item(mk_item(CMD_NOP, 32'hFFFF_FFFF, 6'd63, 32'hFFFF_FFFF));
        send_item(mk_item(CMD_LOG, 32'h0, 6'd0, 32'h0));
        send_item(mk_item(CMD_LOG, 32'hFFFF_FFFF, 6'd63, 32'hFFFF_FFFF));
        send_item(mk_item(CMD_READ, 32'h0, 6'd0, 32'h0));
        send_item(mk_item(CMD_READ, 32'h0, 6'd1, 32'h0));
        send_item(mk_item(CMD_READ, 32'h0, 6'd2, 32'h0));
        send_item(mk_item(CMD_TICK, 32'h0, 6'd0, 32'd59999));
        send_item(mk_item(CMD_TICK, 32'h0, 6'd0, 32'd60000));
        send_item(mk_item(CMD_TICK, 32'h0, 6'd0, 32'd200000));
        send_item(mk_item(CMD_LOG, 32'hA5C3_5A3C, 6'd0, 32'h0));
        send_item(mk_item(CMD_TICK, 32'h0, 6'd0, 32'd119999));
        send_item(mk_item(CMD_TICK, 32'h0, 6'd0, 32'd120000));
        send_item(mk_item(CMD_LOG, 32'h1234_5678, 6'd0, 32'h0));
        // time wrapped since the last save
        send_item(mk_item(CMD_TICK, 32'h0, 6'd0, 32'd5));
        send_item(mk_item(CMD_NOP, 32'h0, 6'd0, 32'h0));
        send_item(mk_item(CMD_READ, 32'h0, 6'd63, 32'h0));
        send_item(mk_item(CMD_READ, 32'h0, 6'd3, 32'h0));
    endtask

    task automatic test_full_ring();
        ring_cmd_t it;
        int        i;
        for (i = 0; i < RING_DEPTH + 8; i++)
        begin
            it = random_cmd();
            it.cmd = CMD_LOG;
            send_item(it);
        end
        for (i = 0; i <= RING_DEPTH; i++)
            send_item(mk_item(CMD_READ, $urandom, 6'(i), $urandom));
        send_item(mk_item(CMD_READ, $urandom, 6'd63, $urandom));
    endtask

    task automatic test_throttle_edges();
        logic [31:0] settings [4];
        int          s;
        int          k;
        settings = '{32'd0, 32'd1, 32'hFFFF_FFFF, 32'd12345};
        for (s = 0; s < 4; s++)
        begin
            write_throttle(settings[s]);
            for (k = 0; k < 3; k++)
            begin
                send_item(mk_item(CMD_LOG, $urandom, 6'd0, 32'h0));
                send_item(mk_item(CMD_TICK, $urandom, 6'd0,
                                  last_save_ms + throttle_ms - 1 + k));
            end
            send_item(mk_item(CMD_TICK, $urandom, 6'd0, last_save_ms));
        end
    endtask

    task automatic test_random_mix(input int unsigned idle_pct, input int unsigned hold_pct,
                                   input logic [31:0] th, input int n);
        int i;
        write_throttle(th);
        sender_idle_pct = idle_pct;
        stall_pct = hold_pct;
        for (i = 0; i < n; i++)
            send_item(random_cmd());
    endtask

    task automatic test_output_hold();
        drain();
        sender_idle_pct = 0;
        stall_pct = 0;
        holds_requested++;
        repeat (30) send_item(random_cmd());
    endtask

    // receiver: random stalls plus a long hold when a test requests one
    initial
    begin
        int i;
        out_ready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (!rst_n)
                out_ready <= 1'b0;
            else if (holds_done < holds_requested)
            begin
                out_ready <= 1'b0;
                for (i = 0; i < HOLD_CYCLES; i++)
                    @(posedge clk);
                holds_done++;
                out_ready <= 1'b1;
            end
            else
                out_ready <= ($urandom_range(99) >= stall_pct);
        end
    end

    function automatic void check_field(string field, logic [31:0] exp_v, logic [31:0] act_v);
        if (act_v !== exp_v)
        begin
            $display("%0t: %s mismatch, expected 0x%0h, got 0x%0h", $time, field, exp_v, act_v);
            mismatches++;
        end
    endfunction

    always @(posedge clk)
    begin
        ring_result_t exp_r;
        if (rst_n && out_valid && out_ready)
        begin
            if (result_q.size() == 0)
            begin
                $display("%0t: result with nothing expected, expected none, got ok=%0b count=%0d",
                         $time, ok, entry_count);
                mismatches++;
            end
            else
            begin
                exp_r = result_q.pop_front();
                check_field("ok", exp_r.ok, ok);
                check_field("save_now", exp_r.save, save_now);
                check_field("entry_count", exp_r.count, entry_count);
                check_field("out_type", exp_r.ev_type, out_type);
                check_field("out_alarm", exp_r.alarm, out_alarm);
                check_field("out_param_one", exp_r.p1, out_param_one);
                check_field("out_param_two", exp_r.p2, out_param_two);
                check_field("out_stamp", exp_r.stamp, out_stamp);
            end
        end
    end

    initial
    begin
        #2000000;
        $display("** event_history_ring_with_save_throttle: FAILED **");
        $finish;
    end

    initial
    begin
        rst_n         = 1'b0;
        cfg_we        = 1'b0;
        cfg_wdata     = '0;
        in_valid      = 1'b0;
        command       = CMD_NOP;
        event_type    = '0;
        alarm_id      = '0;
        param_one     = '0;
        param_two     = '0;
        stamp_seconds = '0;
        age_index     = '0;
        now_ms        = '0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        test_full_ring();
        test_throttle_edges();
        test_random_mix(0, 0, THROTTLE_RESET, 180);
        test_random_mix(53, 0, 32'd0, 180);
        test_random_mix(0, 53, 32'hFFFF_FFFF, 180);
        test_random_mix(12, 12, $urandom, 180);
        test_output_hold();
        drain();
        repeat (10) @(posedge clk);

        $display("run: %0d transfers in, %0d logs, %0d read hits, %0d read misses, %0d saves",
                 n_items, n_logs, n_hits, n_misses, n_saves);
        $display("run: throttle 0, 1, 12345, 60000, max and random; idle and stall mixes, one long hold");
        if (mismatches == 0)
            $display("** event_history_ring_with_save_throttle: PASSED **");
        else
            $display("** event_history_ring_with_save_throttle: FAILED **");
        $finish;
    end

endmodule
